// ===== rtl/core/rce_pkg.sv =====
`default_nettype none

package rce_pkg;

    // Fixed field widths
    localparam int ROW_W  = 16;
    localparam int IDX_W  = 4;
    localparam int SIZE_W = 5;

    typedef logic [ROW_W-1:0] row_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [SIZE_W-1:0] size_t;

    // Contents of one cell of the ring: one matrix row and its tag
    typedef struct packed {
        row_t rel;
        row_t sym;
        row_t clo;
        idx_t tag;
    } cell_t;

    // Pivot row broadcast from the head cell
    typedef struct packed {
        logic en;
        idx_t step;
        row_t rel;
        row_t clo;
    } piv_t;

    // Controller to datapath
    typedef struct packed {
        logic  load_en;
        idx_t  load_idx;
        logic  shift_en;
        logic  piv_en;
        idx_t  step;
        logic  out_valid;
        logic  out_last;
        size_t size;
        row_t  mask;
    } ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CLOSE,
        ST_EMIT
    } state_t;

    function automatic row_t onehot_row(input idx_t i);
        row_t r;
        r    = '0;
        r[i] = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rce_cell.sv =====
`default_nettype none

module rce_cell
    import rce_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  load_sel,
    input  wire idx_t  load_tag,
    input  wire row_t  load_row,
    input  wire logic  shift_en,
    input  wire piv_t  piv,
    input  wire cell_t nbr,
    output cell_t      state,
    output cell_t      upd
);

    cell_t state_reg;
    cell_t state_next;

    // Warshall and transpose update against the broadcast pivot row
    always_comb
    begin
        upd = state_reg;
        if (piv.en)
        begin
            if (state_reg.clo[piv.step])
                upd.clo = state_reg.clo | piv.clo;
            if (piv.rel[state_reg.tag])
                upd.sym = state_reg.sym | onehot_row(piv.step);
        end
    end

    // Load a fresh row, or take the updated row of the next cell in the ring
    always_comb
    begin
        state_next = state_reg;
        if (load_sel)
        begin
            state_next.rel = load_row;
            state_next.sym = load_row;
            state_next.clo = load_row;
            state_next.tag = load_tag;
        end
        else if (shift_en)
        begin
            state_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign state = state_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rce_ctrl.sv =====
`default_nettype none

module rce_ctrl
    import rce_pkg::*;
#(
    parameter int N_CELLS = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_valid,
    input  wire size_t cfg_data,
    input  wire logic  in_valid,
    input  wire logic  out_ready,
    output logic       in_ready,
    output ctl_t       ctl
);

    state_t state_reg;
    state_t state_next;
    size_t  size_reg;
    size_t  size_next;
    idx_t   cnt_reg;
    idx_t   cnt_next;

    size_t  n_eff;
    row_t   mask;
    logic   in_acc;
    logic   out_acc;
    logic   load_done;
    logic   step_done;
    logic   emit_last;

    // Effective size: zero acts as one, large values saturate to the ring length
    always_comb
    begin
        if (size_reg == '0)
            n_eff = SIZE_W'(1);
        else if (size_reg > SIZE_W'(N_CELLS))
            n_eff = SIZE_W'(N_CELLS);
        else
            n_eff = size_reg;
    end

    // Column mask for bits below the size
    always_comb
    begin
        for (int j = 0; j < ROW_W; j++)
            mask[j] = (SIZE_W'(j) < n_eff);
    end

    assign in_acc    = in_valid && (state_reg == ST_LOAD);
    assign out_acc   = out_ready && (state_reg == ST_EMIT);
    assign load_done = ({1'b0, cnt_reg} + SIZE_W'(1)) == n_eff;
    assign step_done = cnt_reg == IDX_W'(N_CELLS - 1);
    assign emit_last = {1'b0, cnt_reg} == (n_eff - SIZE_W'(1));

    // Next state and counter
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        size_next  = size_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (load_done)
                    begin
                        state_next = ST_CLOSE;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end
            end
            ST_CLOSE:
            begin
                if (step_done)
                begin
                    state_next = ST_EMIT;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_EMIT:
            begin
                if (out_acc)
                begin
                    if (emit_last)
                    begin
                        state_next = ST_LOAD;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                cnt_next   = '0;
            end
        endcase
        // A size write drops any matrix in progress and returns to loading
        if (cfg_valid)
        begin
            size_next  = cfg_data;
            state_next = ST_LOAD;
            cnt_next   = '0;
        end
    end

    // Outputs to the datapath
    always_comb
    begin
        in_ready      = 1'b0;
        ctl           = '0;
        ctl.size      = n_eff;
        ctl.mask      = mask;
        ctl.load_idx  = cnt_reg;
        ctl.step      = cnt_reg;
        case (state_reg)
            ST_LOAD:
            begin
                in_ready    = 1'b1;
                ctl.load_en = in_valid;
            end
            ST_CLOSE:
            begin
                ctl.shift_en = 1'b1;
                ctl.piv_en   = {1'b0, cnt_reg} < n_eff;
            end
            ST_EMIT:
            begin
                ctl.out_valid = 1'b1;
                ctl.out_last  = emit_last;
                ctl.shift_en  = out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            size_reg  <= SIZE_W'(16);
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg  <= size_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/relation_closure_engine.sv =====
//  channel | direction | transaction moves
//  --------+-----------+-----------------------------------------------------
//  s_axis  | in        | one matrix row (row_bits)
//  m_axis  | out       | row_index, reflexive, symmetric, transitive rows; tlast
//  cfg     | in        | matrix_size write
//
//  A matrix of n rows is loaded one row per cycle while s_axis_tvalid is high,
//  then one full turn of the ring of min(MAX_SIZE,16) cells runs the Warshall
//  pivots, then the n rows are emitted, one per m_axis transfer.
//  rst_n is asynchronous; the row stores hold no reset value.
//  A stall on m_axis holds the ring; s_axis is not ready while a matrix is
//  being closed or emitted.
`default_nettype none

module relation_closure_engine
    import rce_pkg::*;
#(
    parameter int MAX_SIZE = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // matrix_size
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data,
    // row_bits
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,
    // row_index, reflexive_row, symmetric_row, transitive_row, zero pad
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,
    // last_row
    output logic             m_axis_tlast
);

    localparam int NCELL = (MAX_SIZE < ROW_W) ? MAX_SIZE : ROW_W;

    ctl_t  ctl;
    piv_t  piv;
    cell_t cells [NCELL];
    cell_t upds  [NCELL];
    row_t  load_row;
    cell_t head;

    assign cfg_ready = 1'b1;

    rce_ctrl #(
        .N_CELLS (NCELL)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .out_ready (m_axis_tready),
        .in_ready  (s_axis_tready),
        .ctl       (ctl)
    );

    // Columns at or above the size read as zero
    assign load_row = s_axis_tdata & ctl.mask;

    // Pivot comes from the head of the ring
    assign head     = cells[0];
    assign piv.en   = ctl.piv_en;
    assign piv.step = ctl.step;
    assign piv.rel  = head.rel;
    assign piv.clo  = head.clo;

    // Ring of cells, each one takes its upper neighbor's row on a shift
    for (genvar k = 0; k < NCELL; k++)
    begin : g_cell
        rce_cell u_cell (
            .clk      (clk),
            .load_sel (ctl.load_en && (ctl.load_idx == IDX_W'(k))),
            .load_tag (IDX_W'(k)),
            .load_row (load_row),
            .shift_en (ctl.shift_en),
            .piv      (piv),
            .nbr      (upds[(k + 1) % NCELL]),
            .state    (cells[k]),
            .upd      (upds[k])
        );
    end

    // Result from the head cell
    assign m_axis_tvalid        = ctl.out_valid;
    assign m_axis_tlast         = ctl.out_last;
    assign m_axis_tdata[3:0]    = head.tag;
    assign m_axis_tdata[19:4]   = (head.rel | onehot_row(head.tag)) & ctl.mask;
    assign m_axis_tdata[35:20]  = head.sym & ctl.mask;
    assign m_axis_tdata[51:36]  = head.clo & ctl.mask;
    assign m_axis_tdata[55:52]  = '0;

`ifndef SYNTH
    // Loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while results pending");

    // The final result carries the last row of the matrix
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
            ({1'b0, m_axis_tdata[3:0]} == (ctl.size - SIZE_W'(1))))
        else $error("tlast on wrong row");

    // Loading resumes right after the last result goes out
    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after final result");
`endif

endmodule

`default_nettype wire
